>>> src/canny_edge_stream_core_defines.svh
// assertion macros for the edge detector checker
`ifndef CANNY_EDGE_STREAM_CORE_DEFINES_SVH
`define CANNY_EDGE_STREAM_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ced_pkg.sv
`default_nettype none
package ced_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4095;
    localparam int MIN_SIZE   = 25;
    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W     = (CW > 12) ? CW : 12;

    localparam logic [7:0] EDGE_STRONG = 8'd255;
    localparam logic [7:0] EDGE_WEAK   = 8'd100;
    localparam logic [7:0] EDGE_NONE   = 8'd0;

    localparam logic [6:0] TAN_LOW_Q8  = 7'd106;
    localparam logic [9:0] TAN_HIGH_Q8 = 10'd618;

    localparam logic [1:0] SECTOR_HORIZ    = 2'd0;
    localparam logic [1:0] SECTOR_VERT     = 2'd1;
    localparam logic [1:0] SECTOR_DIAG_POS = 2'd2;
    localparam logic [1:0] SECTOR_DIAG_NEG = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
    localparam logic [1:0] REG_LOW    = 2'd3;

    typedef struct packed {
        logic          rd;
        logic          shift;
        logic          calc;
        logic [AW-1:0] addr;
        logic [7:0]    px;
    } t_pix_ctl;

    typedef struct packed {
        logic          rd;
        logic          shift;
        logic [AW-1:0] addr;
        logic [12:0]   gval;
    } t_grad_ctl;
endpackage
`default_nettype wire

>>> src/ced_pix_stage.sv
`default_nettype none
module ced_pix_stage (
    input  wire logic              i_clk,
    input  wire ced_pkg::t_pix_ctl i_ctl,
    output logic [9:0]             o_abs_gx,
    output logic [9:0]             o_abs_gy,
    output logic                   o_neg_gx,
    output logic                   o_neg_gy
);
    import ced_pkg::*;

    // [15:8] two rows up, [7:0] one row up
    logic [15:0] r_mem [MAX_WIDTH];
    logic [15:0] r_rd_data;
    logic [7:0]  r_win [3][3];
    logic [9:0]  left_sum, right_sum, top_sum, bot_sum;
    logic signed [10:0] gx, gy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_ctl.addr];
        end
        if (i_ctl.shift) begin
            r_mem[i_ctl.addr] <= {r_rd_data[7:0], i_ctl.px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rd_data[15:8];
            r_win[1][2] <= r_rd_data[7:0];
            r_win[2][2] <= i_ctl.px;
        end
    end

    always_comb begin
        left_sum  = {2'b0, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b0, r_win[2][0]};
        right_sum = {2'b0, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b0, r_win[2][2]};
        top_sum   = {2'b0, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b0, r_win[0][2]};
        bot_sum   = {2'b0, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b0, r_win[2][2]};
        gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            o_neg_gx <= gx[10];
            o_neg_gy <= gy[10];
            o_abs_gx <= gx[10] ? 10'(-gx) : gx[9:0];
            o_abs_gy <= gy[10] ? 10'(-gy) : gy[9:0];
        end
    end
endmodule
`default_nettype wire

>>> src/ced_sqrt.sv
`default_nettype none
module ced_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [20:0] i_value,
    output logic             o_busy,
    output logic [10:0]      o_root
);
    logic [21:0] r_val;
    logic [12:0] r_rem;
    logic [3:0]  r_cnt;
    logic [14:0] rem_s, trial;

    // one root bit per cycle, two radicand bits consumed each step
    always_comb begin
        rem_s = {r_rem, r_val[21:20]};
        trial = {2'b0, o_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= 4'd10;
        end else if (o_busy) begin
            if (r_cnt == 4'd0) begin
                o_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= {1'b0, i_value};
            r_rem  <= '0;
            o_root <= '0;
        end else if (o_busy) begin
            r_val <= {r_val[19:0], 2'b00};
            if (rem_s >= trial) begin
                r_rem  <= 13'(rem_s - trial);
                o_root <= {o_root[9:0], 1'b1};
            end else begin
                r_rem  <= rem_s[12:0];
                o_root <= {o_root[9:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> src/ced_nms_stage.sv
`default_nettype none
module ced_nms_stage (
    input  wire logic               i_clk,
    input  wire ced_pkg::t_grad_ctl i_ctl,
    input  wire logic [10:0]        i_high_thr,
    input  wire logic [10:0]        i_low_thr,
    output logic [7:0]              o_level
);
    import ced_pkg::*;

    // [25:13] two rows up, [12:0] one row up
    logic [25:0] r_mem [MAX_WIDTH];
    logic [25:0] r_rd_data;
    logic [12:0] r_win [3][3];
    logic [10:0] mag, n1, n2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_ctl.addr];
        end
        if (i_ctl.shift) begin
            r_mem[i_ctl.addr] <= {r_rd_data[12:0], i_ctl.gval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rd_data[25:13];
            r_win[1][2] <= r_rd_data[12:0];
            r_win[2][2] <= i_ctl.gval;
        end
    end

    always_comb begin
        mag = r_win[1][1][10:0];
        case (r_win[1][1][12:11])
            SECTOR_HORIZ: begin
                n1 = r_win[1][0][10:0];
                n2 = r_win[1][2][10:0];
            end
            SECTOR_VERT: begin
                n1 = r_win[0][1][10:0];
                n2 = r_win[2][1][10:0];
            end
            SECTOR_DIAG_POS: begin
                n1 = r_win[2][2][10:0];
                n2 = r_win[0][0][10:0];
            end
            default: begin
                n1 = r_win[0][2][10:0];
                n2 = r_win[2][0][10:0];
            end
        endcase
        if (!(mag > n1 && mag > n2)) begin
            o_level = EDGE_NONE;
        end else if (mag > i_high_thr) begin
            o_level = EDGE_STRONG;
        end else if (mag > i_low_thr) begin
            o_level = EDGE_WEAK;
        end else begin
            o_level = EDGE_NONE;
        end
    end
endmodule
`default_nettype wire

>>> src/canny_edge_stream_core.sv
// channel  | direction | handshake                | payload
// pixel    | in        | i_valid / o_ready        | i_pixel, i_frame_start
// edge     | out       | o_valid / i_ready        | o_edge_level, o_row_end, o_frame_end
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// a pixel before row 2 or column 2 only updates the pixel line store and window; one in row 2
// or 3 or column 2 or 3 also runs the gradient, square root (11 root bits, one per cycle)
// and gradient line store steps, and an interior pixel also makes an output beat. each line
// store memory is read when the pixel is accepted and written back later, in S_WIN or S_GWIN.
// an interior pixel whose beat finds the previous beat still waiting stays in its
// final step until that beat is taken; otherwise the next pixel is taken while it
// waits. reset is synchronous, needs no clearing pass, config is always ready.
`default_nettype none
module canny_edge_stream_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_pixel,
    input  wire logic        i_frame_start,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_edge_level,
    output logic             o_row_end,
    output logic             o_frame_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);
    import ced_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIN  = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SECT = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_GWIN = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [11:0]   r_width, r_height;
    logic [10:0]   r_high, r_low;
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic [AW-1:0] r_cur_c;
    logic [7:0]    r_px;
    logic          r_g_en, r_o_en, r_last_col, r_last_row;
    logic [19:0]   r_aa, r_bb, r_t2;
    logic [16:0]   r_t1;
    logic [1:0]    r_sec;

    logic [CW-1:0] w;
    logic [11:0]   h;
    logic [CW-1:0] c0, c2, c_inc;
    logic [12:0]   r1, r_inc;
    logic [11:0]   r2;
    logic          accept;
    logic [9:0]    abs_gx, abs_gy;
    logic          neg_gx, neg_gy;
    logic [20:0]   sum_sq;
    logic [19:0]   b256;
    logic          sq_busy;
    logic [10:0]   root;
    logic [7:0]    level;
    t_pix_ctl      pix_ctl;
    t_grad_ctl     grad_ctl;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    always_comb begin
        logic [WCMP_W-1:0] wx;
        wx = WCMP_W'(r_width);
        if (wx < WCMP_W'(MIN_SIZE)) begin
            w = CW'(MIN_SIZE);
        end else if (wx > WCMP_W'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(wx);
        end
        h = (r_height < 12'(MIN_SIZE)) ? 12'(MIN_SIZE) : r_height;
    end

    // position of the accepted pixel and the counters after it
    always_comb begin
        c0 = i_frame_start ? '0 : r_col;
        r1 = i_frame_start ? '0 : {1'b0, r_row};
        if (c0 >= w) begin
            c2 = '0;
            r1 = r1 + 13'd1;
        end else begin
            c2 = c0;
        end
        r2    = (r1 >= {1'b0, h}) ? '0 : r1[11:0];
        c_inc = c2 + CW'(1);
        r_inc = {1'b0, r2} + 13'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_high   <= 11'd200;
            r_low    <= 11'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_HIGH:   r_high   <= i_cfg_data[10:0];
                REG_LOW:    r_low    <= i_cfg_data[10:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (c_inc >= w) begin
                r_col <= '0;
                r_row <= (r_inc >= {1'b0, h}) ? '0 : r_inc[11:0];
            end else begin
                r_col <= c_inc;
                r_row <= r2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_c    <= c2[AW-1:0];
            r_px       <= i_pixel;
            r_g_en     <= (r2 >= 12'd2) && (c2 >= CW'(2));
            r_o_en     <= (r2 >= 12'd4) && (c2 >= CW'(4));
            r_last_col <= (c2 == w - CW'(1));
            r_last_row <= (r2 == h - 12'd1);
        end
    end

    always_comb begin
        pix_ctl.rd     = accept;
        pix_ctl.shift  = (r_state == S_WIN);
        pix_ctl.calc   = (r_state == S_CALC);
        pix_ctl.addr   = accept ? c2[AW-1:0] : r_cur_c;
        pix_ctl.px     = r_px;
        grad_ctl.rd    = accept;
        grad_ctl.shift = (r_state == S_GWIN);
        grad_ctl.addr  = accept ? AW'(c2 - CW'(2)) : AW'(r_cur_c - AW'(2));
        grad_ctl.gval  = {r_sec, root};
    end

    ced_pix_stage u_pix (
        .i_clk    (i_clk),
        .i_ctl    (pix_ctl),
        .o_abs_gx (abs_gx),
        .o_abs_gy (abs_gy),
        .o_neg_gx (neg_gx),
        .o_neg_gy (neg_gy)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQ) begin
            r_aa <= 20'(abs_gx) * 20'(abs_gx);
            r_bb <= 20'(abs_gy) * 20'(abs_gy);
            r_t1 <= 17'(abs_gx) * 17'(TAN_LOW_Q8);
            r_t2 <= 20'(abs_gx) * 20'(TAN_HIGH_Q8);
        end
    end

    assign sum_sq = {1'b0, r_aa} + {1'b0, r_bb};
    assign b256   = {2'b0, abs_gy, 8'd0};

    always_ff @(posedge i_clk) begin
        if (r_state == S_SECT) begin
            if (abs_gx == '0) begin
                r_sec <= SECTOR_VERT;
            end else if (b256 <= {3'b0, r_t1}) begin
                r_sec <= SECTOR_HORIZ;
            end else if (b256 <= r_t2) begin
                r_sec <= (neg_gx == neg_gy) ? SECTOR_DIAG_POS : SECTOR_DIAG_NEG;
            end else begin
                r_sec <= SECTOR_VERT;
            end
        end
    end

    ced_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SECT),
        .i_value (sum_sq),
        .o_busy  (sq_busy),
        .o_root  (root)
    );

    ced_nms_stage u_nms (
        .i_clk      (i_clk),
        .i_ctl      (grad_ctl),
        .i_high_thr (r_high),
        .i_low_thr  (r_low),
        .o_level    (level)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_WIN;
            S_WIN:  n_state = r_g_en ? S_CALC : S_IDLE;
            S_CALC: n_state = S_SQ;
            S_SQ:   n_state = S_SECT;
            S_SECT: n_state = S_SQRT;
            S_SQRT: if (!sq_busy) n_state = S_GWIN;
            S_GWIN: n_state = r_o_en ? S_OUT : S_IDLE;
            S_OUT:  if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!o_valid || i_ready)) begin
            o_edge_level <= level;
            o_row_end    <= r_last_col;
            o_frame_end  <= r_last_col && r_last_row;
        end
    end
endmodule
`default_nettype wire

>>> src/ced_checker.sv
`default_nettype none
`include "canny_edge_stream_core_defines.svh"
module ced_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_edge_level,
    input wire logic       o_row_end,
    input wire logic       o_frame_end
);
    import ced_pkg::*;

    logic level_ok;

    assign level_ok = (o_edge_level == EDGE_NONE) || (o_edge_level == EDGE_WEAK)
                   || (o_edge_level == EDGE_STRONG);

    `CED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `CED_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_edge_level))
    `CED_ASSERT_IMPLY(a_frame_row, i_clk, i_rst_n, o_valid && o_frame_end, o_row_end)
    `CED_ASSERT_IMPLY(a_level_code, i_clk, i_rst_n, o_valid, level_ok)
endmodule

bind canny_edge_stream_core ced_checker u_ced_checker (.*);
`default_nettype wire
